/* hw/rtl/bilinear_texture_sampler_assert.svh */
// Assertion macros for the checker file of the texture sampler.
`ifndef BILINEAR_TEXTURE_SAMPLER_ASSERT_SVH
`define BILINEAR_TEXTURE_SAMPLER_ASSERT_SVH

// Same-cycle implication, checked outside of reset.
`define BTS_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// Next-cycle implication, checked outside of reset.
`define BTS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

/* hw/rtl/bts_pkg.sv */
package bts_pkg;

   // Default sizes of the texel store.
   localparam int NUM_SLOTS_DEF = 4;
   localparam int MAX_DIM_DEF   = 256;

   // Configuration register file: a width and a height per slot.
   localparam int REG_SLOTS = 4;
   localparam int CFG_REGS  = 2 * REG_SLOTS;
   localparam int CSR_IDX_W = 4;
   localparam int DIM_REG_W = 9;
   localparam logic [DIM_REG_W-1:0] DIM_RESET = 9'd256;

   // Low bit of a register index selects width or height.
   localparam logic CSR_WIDTH_SEL  = 1'b0;
   localparam logic CSR_HEIGHT_SEL = 1'b1;

   // Request function codes.
   localparam logic FUNC_LOAD   = 1'b0;
   localparam logic FUNC_SAMPLE = 1'b1;

   // Filter fractions of one sample, aligned with the texel read data.
   typedef struct packed {
      logic        valid;
      logic        zero;
      logic [15:0] ur;
      logic [15:0] vr;
   } frac_type;

endpackage

/* hw/rtl/bts_ram.sv */
module bts_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/bts_addr.sv */
module bts_addr #(
   parameter int AW = 8,
   parameter int SW = 2
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           en,
   input  logic                           in_valid,
   input  logic                           in_func,
   input  logic                           in_slot_ok,
   input  logic                           in_load_ok,
   input  logic [SW-1:0]                  in_slot,
   input  logic [AW-1:0]                  in_lcol,
   input  logic [AW-1:0]                  in_lrow,
   input  logic [31:0]                    in_rgba,
   input  logic [15:0]                    in_fu,
   input  logic [15:0]                    in_fv,
   input  logic                           in_bi,
   input  logic [AW-1:0]                  in_wm1,
   input  logic [AW-1:0]                  in_hm1,
   output logic                           wr_en,
   output logic [SW+2*AW-1:0]             wr_addr,
   output logic [31:0]                    wr_data,
   output logic                           rd_en,
   output logic [3:0][SW+2*AW-1:0]        rd_addr,
   output bts_pkg::frac_type              frac_out
);

   localparam int UW = 16 + AW;
   localparam int VW = 17 + AW;

   logic              v2_ff, func2_ff, slot_ok2_ff, load_ok2_ff, bi2_ff;
   logic [SW-1:0]     slot2_ff;
   logic [AW-1:0]     lcol2_ff, lrow2_ff, wm12_ff, hm12_ff;
   logic [31:0]       rgba2_ff;
   logic [UW-1:0]     uu_ff, uu_in;
   logic [VW-1:0]     vv_ff, vv_in;
   logic [16:0]       fv_inv;
   logic [AW-1:0]     col, row, col1, row1;
   bts_pkg::frac_type frac_ff, frac_in;

   // Scale the u fraction, and the v fraction inverted, by the texture size minus one.
   always_comb begin
      fv_inv = 17'h10000 - {1'b0, in_fv};
      uu_in  = UW'(in_fu) * UW'(in_wm1);
      vv_in  = VW'(fv_inv) * VW'(in_hm1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (en) begin
         v2_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         func2_ff    <= in_func;
         slot_ok2_ff <= in_slot_ok;
         load_ok2_ff <= in_load_ok;
         bi2_ff      <= in_bi;
         slot2_ff    <= in_slot;
         lcol2_ff    <= in_lcol;
         lrow2_ff    <= in_lrow;
         rgba2_ff    <= in_rgba;
         wm12_ff     <= in_wm1;
         hm12_ff     <= in_hm1;
         uu_ff       <= uu_in;
         vv_ff       <= vv_in;
      end
   end

   // Texel coordinates and their right and lower neighbors, wrapping at the edges.
   always_comb begin
      col  = uu_ff[16 +: AW];
      row  = vv_ff[16 +: AW];
      col1 = (col == wm12_ff) ? '0 : AW'(col + 1'b1);
      row1 = (row == hm12_ff) ? '0 : AW'(row + 1'b1);
   end

   // Loads and samples reach the store in request order, so a sample always
   // sees every earlier load.
   assign wr_en      = en && v2_ff && (func2_ff == bts_pkg::FUNC_LOAD) && load_ok2_ff;
   assign wr_addr    = {slot2_ff, lrow2_ff, lcol2_ff};
   assign wr_data    = rgba2_ff;
   assign rd_en      = en;
   assign rd_addr[0] = {slot2_ff, row,  col};
   assign rd_addr[1] = {slot2_ff, row,  col1};
   assign rd_addr[2] = {slot2_ff, row1, col};
   assign rd_addr[3] = {slot2_ff, row1, col1};

   // Nearest sampling uses zero fractions, which puts all weight on the top-left texel.
   always_comb begin
      frac_in.valid = v2_ff && (func2_ff == bts_pkg::FUNC_SAMPLE);
      frac_in.zero  = !slot_ok2_ff;
      frac_in.ur    = bi2_ff ? uu_ff[15:0] : 16'd0;
      frac_in.vr    = bi2_ff ? vv_ff[15:0] : 16'd0;
   end

   // Fractions travel beside the texel read; only the valid bit is reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         frac_ff.valid <= 1'b0;
      end else if (en) begin
         frac_ff.valid <= frac_in.valid;
      end
      if (en) begin
         frac_ff.zero <= frac_in.zero;
         frac_ff.ur   <= frac_in.ur;
         frac_ff.vr   <= frac_in.vr;
      end
   end

   assign frac_out = frac_ff;

endmodule

/* hw/rtl/bts_blend.sv */
module bts_blend (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  bts_pkg::frac_type frac_in,
   input  logic [3:0][31:0]  texel,
   output logic              out_valid,
   output logic [7:0]        out_red,
   output logic [7:0]        out_green,
   output logic [7:0]        out_blue,
   output logic [7:0]        out_alpha
);

   localparam int WW = 34;
   localparam int PW = 42;
   localparam int SUMW = 44;

   logic [16:0]            ur_inv, vr_inv;
   logic [3:0][WW-1:0]     wgt_in, wgt4_ff;
   logic [3:0][31:0]       tex4_ff;
   logic                   v4_ff, zero4_ff, v5_ff, zero5_ff, valid_out_ff;
   logic [3:0][3:0][PW-1:0] prod_in, prod5_ff;
   logic [3:0][SUMW-1:0]   sum;
   logic [3:0][7:0]        chan_in, chan_ff;

   // Bilinear weights; they always add up to 2^32.
   always_comb begin
      ur_inv    = 17'h10000 - {1'b0, frac_in.ur};
      vr_inv    = 17'h10000 - {1'b0, frac_in.vr};
      wgt_in[0] = WW'(ur_inv) * WW'(vr_inv);
      wgt_in[1] = WW'(frac_in.ur) * WW'(vr_inv);
      wgt_in[2] = WW'(ur_inv) * WW'(frac_in.vr);
      wgt_in[3] = WW'(frac_in.ur) * WW'(frac_in.vr);
   end

   // Weight each channel of each texel.
   always_comb begin
      for (int k = 0; k < 4; k++) begin
         for (int t = 0; t < 4; t++) begin
            prod_in[k][t] = PW'(tex4_ff[t][31 - 8*k -: 8]) * PW'(wgt4_ff[t]);
         end
      end
   end

   // Sum the four taps and round half up to 8 bits.
   always_comb begin
      for (int k = 0; k < 4; k++) begin
         sum[k] = SUMW'(prod5_ff[k][0]) + SUMW'(prod5_ff[k][1])
                + SUMW'(prod5_ff[k][2]) + SUMW'(prod5_ff[k][3])
                + SUMW'(64'h8000_0000);
         chan_in[k] = zero5_ff ? 8'd0 : sum[k][39:32];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff        <= 1'b0;
         v5_ff        <= 1'b0;
         valid_out_ff <= 1'b0;
      end else if (en) begin
         v4_ff        <= frac_in.valid;
         v5_ff        <= v4_ff;
         valid_out_ff <= v5_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         wgt4_ff  <= wgt_in;
         tex4_ff  <= texel;
         zero4_ff <= frac_in.zero;
         prod5_ff <= prod_in;
         zero5_ff <= zero4_ff;
         chan_ff  <= chan_in;
      end
   end

   assign out_valid = valid_out_ff;
   assign out_red   = chan_ff[0];
   assign out_green = chan_ff[1];
   assign out_blue  = chan_ff[2];
   assign out_alpha = chan_ff[3];

endmodule

/* hw/rtl/bilinear_texture_sampler.sv */
// Bilinear texture sampler with repeat wrapping.
// Request channel (req_valid, req_stall): a load request (func 0) writes one
// RGBA8 texel at a slot, column and row and gives no response; a sample
// request (func 1) gives exactly one response on rsp_red..rsp_alpha.
// Configuration channel (csr_valid, csr_ready): csr_ready is always high; index
// 2*s writes the width and 2*s+1 the height of slot s. The user must write
// only while the sampler is idle; the block itself does not enforce this.
// A sample passes the request register, address stage, texel store read,
// weight and product stages and output register. Throughput is one request
// per cycle unless the pipeline holds. Four texel store copies, each with its
// own read port, give a sample's four neighbors at once; a load writes all four.
// Reset clears the pipeline and sets every width and height to 256; the texel
// store holds no defined value until written, and needs no clearing pass.
// When the receiver stalls a valid response, the whole pipeline holds and
// req_stall rises in the same cycle, so the response stays on the ports.
module bilinear_texture_sampler #(
   parameter int NUM_SLOTS = bts_pkg::NUM_SLOTS_DEF,
   parameter int MAX_DIM   = bts_pkg::MAX_DIM_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic                           req_func,
   input  logic [1:0]                     req_tex_slot,
   input  logic [7:0]                     req_load_column,
   input  logic [7:0]                     req_load_row,
   input  logic [31:0]                    req_load_rgba,
   input  logic signed [23:0]             req_u_coord,
   input  logic signed [23:0]             req_v_coord,
   input  logic                           req_bilinear,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [7:0]                     rsp_red,
   output logic [7:0]                     rsp_green,
   output logic [7:0]                     rsp_blue,
   output logic [7:0]                     rsp_alpha,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [bts_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [bts_pkg::DIM_REG_W-1:0]  csr_data
);

   localparam int AW     = $clog2(MAX_DIM);
   localparam int SW     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int ADDR_W = SW + 2 * AW;
   localparam int DEPTH  = 1 << ADDR_W;

   logic [bts_pkg::DIM_REG_W-1:0] width_ff  [bts_pkg::REG_SLOTS];
   logic [bts_pkg::DIM_REG_W-1:0] height_ff [bts_pkg::REG_SLOTS];
   logic [bts_pkg::DIM_REG_W-1:0] sel_w, sel_h;
   logic [AW-1:0]     wm1_in, hm1_in;
   logic              en, accept, slot_ok, load_ok;
   logic              s1_valid_ff, s1_func_ff, s1_slot_ok_ff, s1_load_ok_ff, s1_bi_ff;
   logic [SW-1:0]     s1_slot_ff;
   logic [AW-1:0]     s1_lcol_ff, s1_lrow_ff, s1_wm1_ff, s1_hm1_ff;
   logic [31:0]       s1_rgba_ff;
   logic [15:0]       s1_fu_ff, s1_fv_ff;
   logic              wr_en, rd_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [31:0]       wr_data;
   logic [3:0][ADDR_W-1:0] rd_addr;
   logic [3:0][31:0]  texel;
   bts_pkg::frac_type frac;

   // The pipeline moves unless a response waits on a stalled receiver.
   assign en        = !(rsp_valid && rsp_stall);
   assign req_stall = !en;
   assign accept    = req_valid && en;
   assign csr_ready = 1'b1;

   // Width and height registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < bts_pkg::REG_SLOTS; i++) begin
            width_ff[i]  <= bts_pkg::DIM_RESET;
            height_ff[i] <= bts_pkg::DIM_RESET;
         end
      end else if (csr_valid && (int'(csr_index) < bts_pkg::CFG_REGS)) begin
         if (csr_index[0] == bts_pkg::CSR_WIDTH_SEL) begin
            width_ff[csr_index[2:1]] <= csr_data;
         end else begin
            height_ff[csr_index[2:1]] <= csr_data;
         end
      end
   end

   // Size of the addressed slot, less one, with zero read as one and large
   // values saturated to the store size.
   always_comb begin
      sel_w   = width_ff[req_tex_slot];
      sel_h   = height_ff[req_tex_slot];
      wm1_in  = (sel_w == '0) ? '0 :
                (int'(sel_w) > MAX_DIM) ? AW'(MAX_DIM - 1) : AW'(sel_w - 1'b1);
      hm1_in  = (sel_h == '0) ? '0 :
                (int'(sel_h) > MAX_DIM) ? AW'(MAX_DIM - 1) : AW'(sel_h - 1'b1);
      slot_ok = int'(req_tex_slot) < NUM_SLOTS;
      load_ok = slot_ok && (int'(req_load_column) < MAX_DIM)
                && (int'(req_load_row) < MAX_DIM);
   end

   // Request register.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_func_ff    <= req_func;
         s1_slot_ok_ff <= slot_ok;
         s1_load_ok_ff <= load_ok;
         s1_bi_ff      <= req_bilinear;
         s1_slot_ff    <= SW'(req_tex_slot);
         s1_lcol_ff    <= AW'(req_load_column);
         s1_lrow_ff    <= AW'(req_load_row);
         s1_rgba_ff    <= req_load_rgba;
         s1_fu_ff      <= req_u_coord[15:0];
         s1_fv_ff      <= req_v_coord[15:0];
         s1_wm1_ff     <= wm1_in;
         s1_hm1_ff     <= hm1_in;
      end
   end

   bts_addr #(.AW(AW), .SW(SW)) u_addr (
      .clock      (clock),
      .reset      (reset),
      .en         (en),
      .in_valid   (s1_valid_ff),
      .in_func    (s1_func_ff),
      .in_slot_ok (s1_slot_ok_ff),
      .in_load_ok (s1_load_ok_ff),
      .in_slot    (s1_slot_ff),
      .in_lcol    (s1_lcol_ff),
      .in_lrow    (s1_lrow_ff),
      .in_rgba    (s1_rgba_ff),
      .in_fu      (s1_fu_ff),
      .in_fv      (s1_fv_ff),
      .in_bi      (s1_bi_ff),
      .in_wm1     (s1_wm1_ff),
      .in_hm1     (s1_hm1_ff),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .rd_en      (rd_en),
      .rd_addr    (rd_addr),
      .frac_out   (frac)
   );

   // Four copies of the texel store, one per neighbor of a sample.
   for (genvar g = 0; g < 4; g++) begin : g_store
      bts_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram (
         .clock   (clock),
         .wr_en   (wr_en),
         .wr_addr (wr_addr),
         .wr_data (wr_data),
         .rd_en   (rd_en),
         .rd_addr (rd_addr[g]),
         .rd_data (texel[g])
      );
   end

   bts_blend u_blend (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .frac_in   (frac),
      .texel     (texel),
      .out_valid (rsp_valid),
      .out_red   (rsp_red),
      .out_green (rsp_green),
      .out_blue  (rsp_blue),
      .out_alpha (rsp_alpha)
   );

endmodule

/* hw/rtl/bts_checker.sv */
`include "bilinear_texture_sampler_assert.svh"

module bts_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_stall,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic                          csr_ready
);

   // A stalled response stays offered.
   `BTS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid)

   // Requests are held back only while a response waits on the receiver.
   `BTS_ASSERT_IMPLY(a_req_stall_cause, clock, reset, req_stall, rsp_valid && rsp_stall)

   // Reset leaves no response behind.
   `BTS_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid)

   // The configuration port never pushes back.
   `BTS_ASSERT_IMPLY(a_csr_ready, clock, reset, 1'b1, csr_ready)

endmodule

bind bilinear_texture_sampler bts_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .csr_ready (csr_ready)
);
